@@ rtl/core/dlb_pkg.sv @@
package dlb_pkg;

   // list geometry
   localparam int unsigned DLB_ENTRIES = 32;
   localparam int unsigned ALIGN_BYTES = 128;
   localparam int unsigned USED_W      = $clog2(DLB_ENTRIES + 1);
   localparam int unsigned ALIGN_W     = $clog2(ALIGN_BYTES);

   // divider geometry
   localparam int unsigned DIV_DIVIDEND_W = 33;
   localparam int unsigned DIV_DIVISOR_W  = 16;
   localparam int unsigned DIV_COUNT_W    = $clog2(DIV_DIVIDEND_W + 1);

   // request kinds
   localparam logic OP_START  = 1'b0;
   localparam logic OP_REGION = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_STATE   = 3'd1;
   localparam logic [2:0] ST_INVALID     = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
   localparam logic [2:0] ST_OUT_ENTRIES = 3'd4;
   localparam logic [2:0] ST_TOO_SMALL   = 3'd5;

   // register indexes
   localparam logic [1:0] REG_RING_BYTES   = 2'd0;
   localparam logic [1:0] REG_NOTIFY_COUNT = 2'd1;
   localparam logic [1:0] REG_FRAME_BYTES  = 2'd2;

   // divider handshake
   typedef struct packed {
      logic busy;
      logic done;
   } dlb_div_status_type;

endpackage

@@ rtl/core/dlb_divider.sv @@
module dlb_divider (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [dlb_pkg::DIV_DIVIDEND_W-1:0]       dividend,
   input  logic [dlb_pkg::DIV_DIVISOR_W-1:0]        divisor,
   output dlb_pkg::dlb_div_status_type              div_status,
   output logic [dlb_pkg::DIV_DIVIDEND_W-1:0]       quotient,
   output logic [dlb_pkg::DIV_DIVISOR_W-1:0]        remainder
);

   logic [dlb_pkg::DIV_COUNT_W-1:0]    count_ff, count_in;
   logic                               done_ff, done_in;
   logic [dlb_pkg::DIV_DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [dlb_pkg::DIV_DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [dlb_pkg::DIV_DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [dlb_pkg::DIV_DIVISOR_W:0]    trial;
   logic                               fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial    = {rem_ff, quo_ff[dlb_pkg::DIV_DIVIDEND_W-1]};
      fits     = trial >= {1'b0, dvs_ff};
      count_in = count_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start && count_ff == '0) begin
         count_in = dlb_pkg::DIV_COUNT_W'(dlb_pkg::DIV_DIVIDEND_W);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = count_ff == dlb_pkg::DIV_COUNT_W'(1);
         quo_in   = {quo_ff[dlb_pkg::DIV_DIVIDEND_W-2:0], fits};
         if (fits) begin
            rem_in = dlb_pkg::DIV_DIVISOR_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[dlb_pkg::DIV_DIVISOR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_status.busy = count_ff != '0;
   assign div_status.done = done_ff;
   assign quotient        = quo_ff;
   assign remainder       = rem_ff;

endmodule

@@ rtl/core/dma_descriptor_list_builder_unit.sv @@
// channel   | direction | contents
// req_      | in        | tdata {region_size, region_addr}, tuser opcode, tlast last_region
// rsp_      | out       | tdata entry/status fields, tuser is_status, tlast last
// csr_      | in        | ring_bytes @0x0, notify_count @0x4, frame_bytes @0x8
//
// a start runs the shared 33-step divider once (frame check) if frame_bytes is not
// zero, then again (interrupt spacing) if that check passes and notify_count is nonzero
// a region runs S_CALC1, S_CALC2, S_EMIT per entry, and S_STATUS for a closing status
// one item at a time: req_tready is high only while the sequencer is idle
// a stalled rsp_ holds the sequencer at its next result; reset is synchronous
module dma_descriptor_list_builder_unit (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // region_addr[63:0], region_size[103:64]
   input  logic         req_tuser,   // opcode
   input  logic         req_tlast,   // last_region
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // entry_index[5:0], entry_addr[69:6],
                                     // entry_length[101:70], entry_irq[102],
                                     // status[105:103], last_valid_index[111:106]
   output logic         rsp_tuser,   // is_status
   output logic         rsp_tlast,   // last
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV1   = 4'd1;
   localparam logic [3:0] S_DIV2   = 4'd2;
   localparam logic [3:0] S_STATUS = 4'd3;
   localparam logic [3:0] S_CALC1  = 4'd4;
   localparam logic [3:0] S_CALC2  = 4'd5;
   localparam logic [3:0] S_EMIT   = 4'd6;

   localparam int unsigned UW = dlb_pkg::USED_W;

   logic [3:0]  state_ff, state_in;
   logic [31:0] ring_ff, ring_in;
   logic [15:0] notify_ff, notify_in;
   logic [15:0] frame_ff, frame_in;
   logic [31:0] bd_ff, bd_in;
   logic [32:0] nip_ff, nip_in;
   logic [31:0] spacing_ff, spacing_in;
   logic [UW-1:0] used_ff, used_in;
   logic        open_ff, open_in;
   logic [63:0] addr_ff, addr_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] off_ff, off_in;
   logic        lastreg_ff, lastreg_in;
   logic [31:0] todo_ff, todo_in;
   logic [33:0] ipos_ff, ipos_in;
   logic        irq_ff, irq_in;
   logic [2:0]  code_ff, code_in;
   logic [5:0]  lvi_ff, lvi_in;
   logic        ov_ff, ov_in;
   logic        ostat_ff, ostat_in;
   logic [111:0] odata_ff, odata_in;
   logic        olast_ff, olast_in;

   logic        div_start;
   logic [32:0] div_dividend;
   logic [15:0] div_divisor;
   dlb_pkg::dlb_div_status_type div_status;
   logic [32:0] div_quotient;
   logic [15:0] div_remainder;

   logic        req_fire;
   logic        cfg_write;
   logic        slot_free;
   logic [31:0] left_region;
   logic [31:0] left_ring;
   logic [33:0] reach;
   logic [33:0] gap;
   logic [32:0] bd_sum;
   logic [32:0] off_sum;
   logic [UW-1:0] used_next;
   logic        covered;
   logic        full;
   logic        region_done;

   dlb_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .div_status (div_status),
      .quotient   (div_quotient),
      .remainder  (div_remainder)
   );

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = state_ff == S_IDLE;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign slot_free = !ov_ff || rsp_tready;
   assign csr_pready = 1'b1;

   // register read back
   always_comb begin
      unique case (csr_paddr[3:2])
         dlb_pkg::REG_RING_BYTES:   csr_prdata = ring_ff;
         dlb_pkg::REG_NOTIFY_COUNT: csr_prdata = {16'd0, notify_ff};
         dlb_pkg::REG_FRAME_BYTES:  csr_prdata = {16'd0, frame_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // per-entry arithmetic
   always_comb begin
      left_region = size_ff - off_ff;
      left_ring   = ring_ff - bd_ff;
      reach       = {2'b00, bd_ff} + {2'b00, todo_ff};
      gap         = ipos_ff - {2'b00, bd_ff};
      bd_sum      = {1'b0, bd_ff} + {1'b0, todo_ff};
      off_sum     = {1'b0, off_ff} + {1'b0, todo_ff};
      used_next   = used_ff + 1'b1;
      covered     = bd_sum >= {1'b0, ring_ff};
      full        = used_next >= UW'(dlb_pkg::DLB_ENTRIES);
      region_done = off_sum >= {1'b0, size_ff};
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ring_in    = ring_ff;
      notify_in  = notify_ff;
      frame_in   = frame_ff;
      bd_in      = bd_ff;
      nip_in     = nip_ff;
      spacing_in = spacing_ff;
      used_in    = used_ff;
      open_in    = open_ff;
      addr_in    = addr_ff;
      size_in    = size_ff;
      off_in     = off_ff;
      lastreg_in = lastreg_ff;
      todo_in    = todo_ff;
      ipos_in    = ipos_ff;
      irq_in     = irq_ff;
      code_in    = code_ff;
      lvi_in     = lvi_ff;
      ov_in      = ov_ff && !rsp_tready;
      ostat_in   = ostat_ff;
      odata_in   = odata_ff;
      olast_in   = olast_ff;
      div_start    = 1'b0;
      div_dividend = {1'b0, ring_ff};
      div_divisor  = frame_ff;

      // register writes
      if (cfg_write) begin
         unique case (csr_paddr[3:2])
            dlb_pkg::REG_RING_BYTES:   ring_in   = csr_pwdata;
            dlb_pkg::REG_NOTIFY_COUNT: notify_in = csr_pwdata[15:0];
            dlb_pkg::REG_FRAME_BYTES:  frame_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               lvi_in = '0;
               if (req_tuser == dlb_pkg::OP_START) begin
                  open_in = 1'b0;
                  if (frame_ff == '0) begin
                     code_in  = dlb_pkg::ST_BAD_STATE;
                     state_in = S_STATUS;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV1;
                  end
               end else if (!open_ff) begin
                  code_in  = dlb_pkg::ST_BAD_STATE;
                  state_in = S_STATUS;
               end else if (req_tdata[103:96] != '0) begin
                  open_in  = 1'b0;
                  code_in  = dlb_pkg::ST_TOO_LARGE;
                  state_in = S_STATUS;
               end else begin
                  addr_in    = req_tdata[63:0];
                  size_in    = req_tdata[95:64];
                  off_in     = '0;
                  lastreg_in = req_tlast;
                  if (req_tdata[95:64] != '0) begin
                     state_in = S_CALC1;
                  end else if (req_tlast) begin
                     open_in  = 1'b0;
                     code_in  = dlb_pkg::ST_TOO_SMALL;
                     state_in = S_STATUS;
                  end
               end
            end
         end

         // frame divisibility check, ring and notify_count bounds
         S_DIV1: begin
            if (div_status.done) begin
               if (ring_ff == '0 || div_remainder != '0 ||
                   notify_ff > 16'(dlb_pkg::DLB_ENTRIES)) begin
                  code_in  = dlb_pkg::ST_INVALID;
                  state_in = S_STATUS;
               end else if (notify_ff == '0) begin
                  spacing_in = '0;
                  nip_in     = '0;
                  bd_in      = '0;
                  used_in    = '0;
                  open_in    = 1'b1;
                  code_in    = dlb_pkg::ST_OK;
                  state_in   = S_STATUS;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = {1'b0, ring_ff} + {17'd0, notify_ff} - 33'd1;
                  div_divisor  = notify_ff;
                  state_in     = S_DIV2;
               end
            end
         end

         // interrupt spacing, rounded up
         S_DIV2: begin
            div_divisor = notify_ff;
            if (div_status.done) begin
               spacing_in = div_quotient[31:0];
               nip_in     = div_quotient;
               bd_in      = '0;
               used_in    = '0;
               open_in    = 1'b1;
               code_in    = dlb_pkg::ST_OK;
               state_in   = S_STATUS;
            end
         end

         S_STATUS: begin
            if (slot_free) begin
               ov_in    = 1'b1;
               ostat_in = 1'b1;
               odata_in = {lvi_ff, code_ff, 1'b0, 32'd0, 64'd0, 6'd0};
               olast_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         // clip to region and ring, align the next interrupt point
         S_CALC1: begin
            todo_in  = (left_region > left_ring) ? left_ring : left_region;
            ipos_in  = ({1'b0, nip_ff} + 34'(dlb_pkg::ALIGN_BYTES - 1)) &
                       ~34'(dlb_pkg::ALIGN_BYTES - 1);
            state_in = S_CALC2;
         end

         // interrupt decision and length cut
         S_CALC2: begin
            irq_in = 1'b0;
            if (spacing_ff != '0 && reach >= ipos_ff) begin
               irq_in = 1'b1;
               nip_in = nip_ff + {1'b0, spacing_ff};
               if (ipos_ff <= {2'b00, bd_ff}) begin
                  if (todo_ff > 32'(dlb_pkg::ALIGN_BYTES)) begin
                     todo_in = 32'(dlb_pkg::ALIGN_BYTES);
                  end
               end else if ({2'b00, todo_ff} > gap) begin
                  todo_in = gap[31:0];
               end
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (slot_free) begin
               ov_in    = 1'b1;
               ostat_in = 1'b0;
               odata_in = {6'd0, 3'd0, irq_ff, todo_ff, addr_ff + {32'd0, off_ff},
                           used_ff[5:0]};
               olast_in = !covered && !full && region_done && !lastreg_ff;
               bd_in    = bd_sum[31:0];
               off_in   = off_sum[31:0];
               used_in  = used_next;
               lvi_in   = '0;
               if (covered) begin
                  open_in  = 1'b0;
                  code_in  = dlb_pkg::ST_OK;
                  lvi_in   = used_ff[5:0];
                  state_in = S_STATUS;
               end else if (full) begin
                  open_in  = 1'b0;
                  code_in  = dlb_pkg::ST_OUT_ENTRIES;
                  state_in = S_STATUS;
               end else if (!region_done) begin
                  state_in = S_CALC1;
               end else if (lastreg_ff) begin
                  open_in  = 1'b0;
                  code_in  = dlb_pkg::ST_TOO_SMALL;
                  state_in = S_STATUS;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ring_ff    <= '0;
         notify_ff  <= '0;
         frame_ff   <= '0;
         bd_ff      <= '0;
         nip_ff     <= '0;
         spacing_ff <= '0;
         used_ff    <= '0;
         open_ff    <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ring_ff    <= ring_in;
         notify_ff  <= notify_in;
         frame_ff   <= frame_in;
         bd_ff      <= bd_in;
         nip_ff     <= nip_in;
         spacing_ff <= spacing_in;
         used_ff    <= used_in;
         open_ff    <= open_in;
         ov_ff      <= ov_in;
      end
      addr_ff    <= addr_in;
      size_ff    <= size_in;
      off_ff     <= off_in;
      lastreg_ff <= lastreg_in;
      todo_ff    <= todo_in;
      ipos_ff    <= ipos_in;
      irq_ff     <= irq_in;
      code_ff    <= code_in;
      lvi_ff     <= lvi_in;
      ostat_ff   <= ostat_in;
      odata_ff   <= odata_in;
      olast_ff   <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ostat_ff;
   assign rsp_tlast  = olast_ff;

endmodule
